@@ design/c2d_pkg.sv @@
// Shared types, sizes and register codes of the 5x5 RGB convolution block.
// Used by every module of the block; depends on nothing.
package c2d_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int KERNEL_SIZE = 5;
  localparam int CHANNELS    = 3;
  localparam int LINES       = KERNEL_SIZE - 1;
  localparam int ADDR_W      = $clog2(MAX_WIDTH);
  localparam int SLOT_W      = $clog2(LINES);

  localparam int WIDTH_W  = 12;
  localparam int HEIGHT_W = 16;
  localparam int COL_W    = 12;
  localparam int ROW_W    = 17;
  localparam int TAP_W    = 12;
  localparam int COEF_W   = TAP_W * KERNEL_SIZE;
  localparam int SAMP_W   = 8;
  localparam int PIX_W    = 3 * SAMP_W;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W   = 11;

  localparam int PROD_W = SAMP_W + 1 + TAP_W;
  localparam int RSUM_W = PROD_W + 3;
  localparam int TSUM_W = RSUM_W + 3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_COEF0  = 3'd2,
    CFG_COEF1  = 3'd3,
    CFG_COEF2  = 3'd4,
    CFG_COEF3  = 3'd5,
    CFG_COEF4  = 3'd6
  } cfg_idx_e;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;
  localparam logic [KERNEL_SIZE-1:0][COEF_W-1:0] COEF_RESET = {
    60'd2253862287302664,
    60'd8452498910576670,
    60'd14931579231809589,
    60'd8452498910576670,
    60'd2253862287302664
  };

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [KERNEL_SIZE-1:0][COEF_W-1:0] coef_t;

  // One window column plus what the back end does with it
  typedef struct packed {
    pix_t [KERNEL_SIZE-1:0] col;
    logic                   clear;
    logic                   emit;
    logic                   eof;
  } col_item_t;

endpackage

@@ design/c2d_front.sv @@
// Front end: grid scan, padding decisions and the four-row line store.
// Depends on c2d_pkg; feeds window columns to the column queue.
module c2d_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [c2d_pkg::WIDTH_W-1:0]  width_i,
  input  logic [c2d_pkg::HEIGHT_W-1:0] height_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        in_cmd_i,
  input  c2d_pkg::pix_t               in_pix_i,
  output logic                        col_valid_o,
  output c2d_pkg::col_item_t          col_o,
  input  logic                        col_ready_i
);
  import c2d_pkg::*;

  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic                accept, push, in_frame;
  logic [COL_W:0]      col_inc;
  logic [ROW_W:0]      row_inc;
  logic [LINES-1:0]    rd_ok;
  pix_t                pix;

  logic                s1_valid_q;
  logic [ADDR_W-1:0]   s1_addr_q;
  logic [SLOT_W-1:0]   s1_slot_q;
  pix_t                s1_pix_q;
  logic                s1_inside_q;
  logic [LINES-1:0]    s1_rd_ok_q;
  logic                s1_clear_q, s1_emit_q, s1_eof_q;
  pix_t                rd_q [LINES];

  // Clamp the programmed size
  always_comb begin
    w_eff = width_i;
    if (w_eff == '0) w_eff = WIDTH_W'(1);
    if (int'(w_eff) > MAX_WIDTH) w_eff = WIDTH_W'(MAX_WIDTH);
    h_eff = height_i;
    if (h_eff == '0) h_eff = HEIGHT_W'(1);
  end

  assign in_ready_o = !s1_valid_q || col_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push       = s1_valid_q && col_ready_i;

  // Classify the grid position
  always_comb begin
    in_frame = (row_q < ROW_W'(h_eff)) && (col_q < COL_W'(w_eff));
    pix      = (in_frame && !in_cmd_i) ? in_pix_i : '0;
    for (int i = 0; i < LINES; i++) begin
      rd_ok[i] = (col_q < COL_W'(w_eff)) && (row_q >= ROW_W'(LINES - i))
              && ((row_q - ROW_W'(LINES - i)) < ROW_W'(h_eff));
    end
  end

  // Advance the scan position
  always_comb begin
    col_inc = {1'b0, col_q} + (COL_W+1)'(1);
    row_inc = {1'b0, row_q} + (ROW_W+1)'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (accept) begin
      if (col_inc >= ((COL_W+1)'(w_eff) + (COL_W+1)'(2))) begin
        col_d = '0;
        if (row_inc >= ((ROW_W+1)'(h_eff) + (ROW_W+1)'(2))) row_d = '0;
        else row_d = row_inc[ROW_W-1:0];
      end else begin
        col_d = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept) s1_valid_q <= 1'b1;
      else if (push) s1_valid_q <= 1'b0;
    end
  end

  // Hold the accepted item while its line store read completes
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q   <= col_q[ADDR_W-1:0];
      s1_slot_q   <= row_q[SLOT_W-1:0];
      s1_pix_q    <= pix;
      s1_inside_q <= in_frame;
      s1_rd_ok_q  <= rd_ok;
      s1_clear_q  <= (col_q == '0);
      s1_emit_q   <= (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
      s1_eof_q    <= (row_q == ROW_W'(h_eff) + ROW_W'(1))
                  && (col_q == COL_W'(w_eff) + COL_W'(1));
    end
  end

  // One line store per row slot, read on accept, written on push
  for (genvar s = 0; s < LINES; s++) begin : g_line
    pix_t mem [MAX_WIDTH];
    always_ff @(posedge clk_i) begin
      if (accept) rd_q[s] <= mem[col_q[ADDR_W-1:0]];
      if (push && s1_inside_q && (s1_slot_q == SLOT_W'(s))) mem[s1_addr_q] <= s1_pix_q;
    end
  end

  // Build the new window column, oldest row first
  always_comb begin
    logic [SLOT_W-1:0] sl;
    for (int i = 0; i < LINES; i++) begin
      sl = s1_slot_q + SLOT_W'(i);
      col_o.col[i] = s1_rd_ok_q[i] ? rd_q[sl] : '0;
    end
    col_o.col[KERNEL_SIZE-1] = s1_pix_q;
    col_o.clear = s1_clear_q;
    col_o.emit  = s1_emit_q;
    col_o.eof   = s1_eof_q;
  end

  assign col_valid_o = s1_valid_q;

endmodule

@@ design/c2d_fifo.sv @@
// Short queue of window columns between the front and back ends.
// Depends on c2d_pkg for the column type and depth.
module c2d_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  c2d_pkg::col_item_t push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output c2d_pkg::col_item_t pop_data_o
);
  import c2d_pkg::*;

  col_item_t           mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_q, rd_q;
  logic [FIFO_AW:0]    cnt_q;
  logic                push, pop;

  assign push_ready_o = (cnt_q != (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + FIFO_AW'(1);
      if (pop)  rd_q <= rd_q + FIFO_AW'(1);
      if (push && !pop) cnt_q <= cnt_q + (FIFO_AW+1)'(1);
      else if (pop && !push) cnt_q <= cnt_q - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

  a_fill_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + (FIFO_AW+1)'(1))
    else $error("queue count did not rise on push");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> cnt_q == $past(cnt_q) - (FIFO_AW+1)'(1))
    else $error("queue count did not fall on pop");
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH) && (((wr_q - rd_q) == cnt_q[FIFO_AW-1:0])))
    else $error("queue pointers and count disagree");

endmodule

@@ design/c2d_back.sv @@
// Back end: 5x5 window, multiply, add tree, truncate and saturate, output register.
// Depends on c2d_pkg; takes window columns from the column queue.
module c2d_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  c2d_pkg::coef_t             coef_i,
  input  logic                       col_valid_i,
  output logic                       col_ready_o,
  input  c2d_pkg::col_item_t         col_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output c2d_pkg::pix_t              out_pix_o,
  output logic                       out_eof_o
);
  import c2d_pkg::*;

  localparam int K = KERNEL_SIZE;

  logic adv, pop;
  pix_t win_q [K][K];
  logic v1_q, v2_q, v3_q, v4_q, e1_q, e2_q, e3_q, e4_q;
  logic signed [PROD_W-1:0] prod_q [CHANNELS][K][K];
  logic signed [RSUM_W-1:0] rsum_q [CHANNELS][K];
  logic signed [TSUM_W-1:0] tsum_q [CHANNELS];
  logic   out_valid_q, out_eof_q;
  pix_t   out_pix_q, out_pix_d;

  assign adv         = !out_valid_q || out_ready_i;
  assign pop         = col_valid_i && adv;
  assign col_ready_o = adv;

  // Shift the window by one column, clear it at the left edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < K; i++)
        for (int j = 0; j < K; j++) win_q[i][j] <= '0;
    end else if (pop) begin
      for (int i = 0; i < K; i++) begin
        for (int j = 0; j < K - 1; j++) win_q[i][j] <= col_i.clear ? '0 : win_q[i][j+1];
        win_q[i][K-1] <= col_i.col[i];
      end
    end
  end

  // Track result-bearing items down the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q <= pop && col_i.emit;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      out_valid_q <= v4_q;
    end
  end

  // Products, row sums, totals
  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_q <= col_i.eof;
      e2_q <= e1_q;
      e3_q <= e2_q;
      e4_q <= e3_q;
      out_eof_q <= e4_q;
      out_pix_q <= out_pix_d;
      for (int k = 0; k < CHANNELS; k++) begin
        for (int i = 0; i < K; i++) begin
          for (int j = 0; j < K; j++) begin
            prod_q[k][i][j] <= PROD_W'($signed({1'b0, win_q[i][j][SAMP_W*k +: SAMP_W]})
                             * $signed(coef_i[i][TAP_W*j +: TAP_W]));
          end
          rsum_q[k][i] <= RSUM_W'(prod_q[k][i][0]) + RSUM_W'(prod_q[k][i][1])
                        + RSUM_W'(prod_q[k][i][2]) + RSUM_W'(prod_q[k][i][3])
                        + RSUM_W'(prod_q[k][i][4]);
        end
        tsum_q[k] <= TSUM_W'(rsum_q[k][0]) + TSUM_W'(rsum_q[k][1])
                   + TSUM_W'(rsum_q[k][2]) + TSUM_W'(rsum_q[k][3])
                   + TSUM_W'(rsum_q[k][4]);
      end
    end
  end

  // Drop the fraction, clip to one byte
  always_comb begin
    logic [TSUM_W-FRAC_W-1:0] q;
    out_pix_d = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      q = tsum_q[k][TSUM_W-1:FRAC_W];
      if (tsum_q[k] > 0) begin
        if (q > (TSUM_W-FRAC_W)'(255)) out_pix_d[SAMP_W*k +: SAMP_W] = 8'hFF;
        else out_pix_d[SAMP_W*k +: SAMP_W] = q[SAMP_W-1:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_pix_q;
  assign out_eof_o   = out_eof_q;

endmodule

@@ design/conv2d_5x5_rgb_stream_top.sv @@
// Top level of the 5x5 zero-padded RGB convolution: configuration registers and wiring.
// Depends on c2d_pkg, c2d_front, c2d_fifo and c2d_back.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata[23:0] red,green,blue; tuser command
//  m_axis    out  tvalid/tready          tdata[23:0] red,green,blue; tlast end_of_frame
//  cfg       in   cfg_we_i (no wait)     cfg_idx_i, cfg_data_i[59:0]
//
// One grid item is taken per clock while the column queue has room.
// The rate is set by the line stores, each with one read and one write port per item.
// Reset clears the scan position, the window and all valid flags; no clearing pass.
// Output stalls fill a 4-deep column queue before the input side stops taking items.
module conv2d_5x5_rgb_stream_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,  // red, green, blue
  input  logic                          s_axis_tuser,  // command
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,  // red, green, blue
  output logic                          m_axis_tlast,  // end_of_frame
  input  logic                          cfg_we_i,
  input  logic [c2d_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [c2d_pkg::COEF_W-1:0]    cfg_data_i
);
  import c2d_pkg::*;

  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  coef_t               coef_q;
  logic                fr_valid, fr_ready, bk_valid, bk_ready;
  col_item_t           fr_item, bk_item;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      coef_q   <= COEF_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  width_q   <= cfg_data_i[WIDTH_W-1:0];
        CFG_HEIGHT: height_q  <= cfg_data_i[HEIGHT_W-1:0];
        CFG_COEF0:  coef_q[0] <= cfg_data_i;
        CFG_COEF1:  coef_q[1] <= cfg_data_i;
        CFG_COEF2:  coef_q[2] <= cfg_data_i;
        CFG_COEF3:  coef_q[3] <= cfg_data_i;
        CFG_COEF4:  coef_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  c2d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .width_i     (width_q),
    .height_i    (height_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser),
    .in_pix_i    (s_axis_tdata),
    .col_valid_o (fr_valid),
    .col_o       (fr_item),
    .col_ready_i (fr_ready)
  );

  c2d_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_item),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_item)
  );

  c2d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_q),
    .col_valid_i (bk_valid),
    .col_ready_o (bk_ready),
    .col_i       (bk_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pix_o   (m_axis_tdata),
    .out_eof_o   (m_axis_tlast)
  );

endmodule
